// File: rtl/core/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants for the LZSS stream depacker.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned COUNT_W  = 24;
    localparam int unsigned LEN_W    = 5;   // match length 3..18
    localparam int unsigned OFS_W    = 13;  // match offset 1..4096
    localparam int unsigned MIN_RUN  = 3;
    localparam int unsigned LEN_SHIFT = 12;
    localparam logic [11:0] OFS_MASK = 12'hfff;
    localparam int unsigned TOP_FLAG_BIT = 7;

    // packed-stream parser phase
    localparam logic [1:0] PH_CONTROL  = 2'd0;
    localparam logic [1:0] PH_LITERAL  = 2'd1;
    localparam logic [1:0] PH_TOKEN_HI = 2'd2;
    localparam logic [1:0] PH_TOKEN_LO = 2'd3;

    // result sideband, lowest bit is has_byte
    typedef struct packed {
        logic bad_stream;
        logic done_ok;
        logic has_byte;
    } res_flags_t;

endpackage

// File: rtl/core/lzsd_ram.sv
// ----------------------------------------------------------------------------
// lzsd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzsd_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 4096,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/lzss_stream_depacker.sv
// A literal or status result is registered into the output at the input transfer; a match
// token's bytes pass the history RAM read register and then the output register. While
// the output is free, input takes one packed byte per cycle for control, literal and
// token-high bytes, and a match reads history and emits one byte per cycle; a match holds
// input until its copy, clipped to the length left, is done; short input adds a status.
// Reset: aresetn synchronous active low; clears control state and output_length.
// ----------------------------------------------------------------------------
// lzss_stream_depacker
// LZSS depacker with a 4096-byte history window held in a block RAM.
// ----------------------------------------------------------------------------
module lzss_stream_depacker #(
    parameter int unsigned WINDOW_DEPTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,   // output_length
    // packed input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] in_byte
    input  logic [0:0]  s_tuser,       // [0] stream_first
    input  logic        s_tlast,       // stream_last
    // unpacked output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] out_byte
    output logic [2:0]  m_tuser,       // [0] has_byte, [1] done_ok, [2] bad_stream
    output logic        m_tlast        // run_last
);

    localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COPY = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  flag_byte_reg, flag_byte_next;
    logic [3:0]  flags_left_reg, flags_left_next;
    logic [7:0]  token_high_reg, token_high_next;
    logic [23:0] bw_reg, bw_next;
    logic        finished_reg, finished_next;
    logic [23:0] out_len_reg;
    logic [12:0] offset_reg, offset_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        last_in_reg, last_in_next;
    logic        fwd_reg, fwd_next;
    logic [7:0]  last_byte_reg, last_byte_next;

    logic                m_valid_reg;
    logic [7:0]          m_data_reg;
    lzsd_pkg::res_flags_t m_flags_reg;
    logic                m_last_reg;

    logic                out_load;
    logic [7:0]          out_data;
    lzsd_pkg::res_flags_t out_flags;
    logic                out_last;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [7:0]        ram_rd_data;

    logic        out_free;
    logic        accept;
    logic        first;
    logic [23:0] bw_eff;
    logic        fin_eff;
    logic [1:0]  phase_eff;
    logic [7:0]  fb_eff;
    logic [3:0]  fl_eff;
    logic [7:0]  th_eff;
    logic [7:0]  nf_byte;
    logic [3:0]  nf_left;
    logic [1:0]  nf_phase;
    logic [15:0] token;
    logic [12:0] tok_ofs;
    logic [4:0]  tok_len;
    logic [23:0] room;
    logic [23:0] bw_inc;
    logic [7:0]  copy_byte;
    logic        copy_done;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign first    = s_tuser[0];

    assign bw_eff    = first ? '0 : bw_reg;
    assign fin_eff   = first ? 1'b0 : finished_reg;
    assign phase_eff = first ? lzsd_pkg::PH_CONTROL : phase_reg;
    assign fb_eff    = first ? '0 : flag_byte_reg;
    assign fl_eff    = first ? '0 : flags_left_reg;
    assign th_eff    = first ? '0 : token_high_reg;

    assign nf_byte  = {fb_eff[6:0], 1'b0};
    assign nf_left  = fl_eff - 4'd1;
    assign nf_phase = (nf_left == 4'd0) ? lzsd_pkg::PH_CONTROL :
                      (nf_byte[lzsd_pkg::TOP_FLAG_BIT] ? lzsd_pkg::PH_LITERAL
                                                       : lzsd_pkg::PH_TOKEN_HI);

    assign token   = {th_eff, s_tdata};
    assign tok_ofs = {1'b0, token[11:0] & lzsd_pkg::OFS_MASK} + 13'd1;
    assign tok_len = {1'b0, token[15:lzsd_pkg::LEN_SHIFT]} + 5'(lzsd_pkg::MIN_RUN);
    assign room    = out_len_reg - bw_eff;

    // same-entry read-during-write only happens for offset 1: reuse the last byte
    assign copy_byte = fwd_reg ? last_byte_reg : ram_rd_data;
    assign bw_inc    = bw_reg + 24'd1;
    assign copy_done = bw_inc >= out_len_reg;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        flag_byte_next  = flag_byte_reg;
        flags_left_next = flags_left_reg;
        token_high_next = token_high_reg;
        bw_next         = bw_reg;
        finished_next   = finished_reg;
        offset_next     = offset_reg;
        cnt_next        = cnt_reg;
        last_in_next    = last_in_reg;
        fwd_next        = fwd_reg;
        last_byte_next  = last_byte_reg;
        out_load        = 1'b0;
        out_data        = '0;
        out_flags       = '0;
        out_last        = 1'b0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = bw_reg[ADDR_W-1:0];
        ram_wr_data     = s_tdata;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = bw_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    bw_next         = bw_eff;
                    finished_next   = fin_eff;
                    phase_next      = phase_eff;
                    flag_byte_next  = fb_eff;
                    flags_left_next = fl_eff;
                    token_high_next = th_eff;
                    if (!fin_eff) begin
                        if (bw_eff >= out_len_reg) begin
                            finished_next     = 1'b1;
                            out_load          = 1'b1;
                            out_flags.done_ok = 1'b1;
                            out_last          = 1'b1;
                        end else begin
                            unique case (phase_eff)
                                lzsd_pkg::PH_CONTROL: begin
                                    flag_byte_next  = s_tdata;
                                    flags_left_next = 4'd8;
                                    phase_next = s_tdata[lzsd_pkg::TOP_FLAG_BIT] ?
                                                 lzsd_pkg::PH_LITERAL :
                                                 lzsd_pkg::PH_TOKEN_HI;
                                    if (s_tlast) begin
                                        finished_next        = 1'b1;
                                        out_load             = 1'b1;
                                        out_flags.bad_stream = 1'b1;
                                        out_last             = 1'b1;
                                    end
                                end
                                lzsd_pkg::PH_LITERAL: begin
                                    ram_wr_en          = 1'b1;
                                    ram_wr_addr        = bw_eff[ADDR_W-1:0];
                                    ram_wr_data        = s_tdata;
                                    bw_next            = bw_eff + 24'd1;
                                    flag_byte_next     = nf_byte;
                                    flags_left_next    = nf_left;
                                    phase_next         = nf_phase;
                                    out_load           = 1'b1;
                                    out_data           = s_tdata;
                                    out_flags.has_byte = 1'b1;
                                    if (bw_eff + 24'd1 >= out_len_reg) begin
                                        out_flags.done_ok = 1'b1;
                                        finished_next     = 1'b1;
                                        out_last          = 1'b1;
                                    end else if (s_tlast) begin
                                        state_next = ST_TAIL;
                                    end else begin
                                        out_last = 1'b1;
                                    end
                                end
                                lzsd_pkg::PH_TOKEN_HI: begin
                                    token_high_next = s_tdata;
                                    phase_next      = lzsd_pkg::PH_TOKEN_LO;
                                    if (s_tlast) begin
                                        finished_next        = 1'b1;
                                        out_load             = 1'b1;
                                        out_flags.bad_stream = 1'b1;
                                        out_last             = 1'b1;
                                    end
                                end
                                default: begin
                                    if ({11'd0, tok_ofs} > bw_eff) begin
                                        finished_next        = 1'b1;
                                        out_load             = 1'b1;
                                        out_flags.bad_stream = 1'b1;
                                        out_last             = 1'b1;
                                    end else begin
                                        flag_byte_next  = nf_byte;
                                        flags_left_next = nf_left;
                                        phase_next      = nf_phase;
                                        offset_next     = tok_ofs;
                                        cnt_next        = (room < {19'd0, tok_len}) ?
                                                          room[4:0] : tok_len;
                                        last_in_next    = s_tlast;
                                        fwd_next        = 1'b0;
                                        ram_rd_en       = 1'b1;
                                        ram_rd_addr     = bw_eff[ADDR_W-1:0]
                                                          - tok_ofs[ADDR_W-1:0];
                                        state_next      = ST_COPY;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
            ST_COPY: begin
                if (out_free) begin
                    ram_wr_en          = 1'b1;
                    ram_wr_addr        = bw_reg[ADDR_W-1:0];
                    ram_wr_data        = copy_byte;
                    ram_rd_en          = 1'b1;
                    ram_rd_addr        = bw_inc[ADDR_W-1:0] - offset_reg[ADDR_W-1:0];
                    bw_next            = bw_inc;
                    cnt_next           = cnt_reg - 5'd1;
                    fwd_next           = (offset_reg == 13'd1);
                    last_byte_next     = copy_byte;
                    out_load           = 1'b1;
                    out_data           = copy_byte;
                    out_flags.has_byte = 1'b1;
                    if (copy_done) begin
                        out_flags.done_ok = 1'b1;
                        finished_next     = 1'b1;
                        out_last          = 1'b1;
                        state_next        = ST_IDLE;
                    end else if (cnt_reg == 5'd1) begin
                        if (last_in_reg) begin
                            state_next = ST_TAIL;
                        end else begin
                            out_last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_TAIL: begin
                // input ran out before the output length was reached
                if (out_free) begin
                    finished_next        = 1'b1;
                    out_load             = 1'b1;
                    out_flags.bad_stream = 1'b1;
                    out_last             = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= lzsd_pkg::PH_CONTROL;
            flag_byte_reg  <= '0;
            flags_left_reg <= '0;
            token_high_reg <= '0;
            bw_reg         <= '0;
            finished_reg   <= 1'b0;
            out_len_reg    <= '0;
            cnt_reg        <= '0;
            last_in_reg    <= 1'b0;
            fwd_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_byte_reg  <= flag_byte_next;
            flags_left_reg <= flags_left_next;
            token_high_reg <= token_high_next;
            bw_reg         <= bw_next;
            finished_reg   <= finished_next;
            cnt_reg        <= cnt_next;
            last_in_reg    <= last_in_next;
            fwd_reg        <= fwd_next;
            if (cfg_wr_en) begin
                out_len_reg <= cfg_wr_data;
            end
            if (out_free) begin
                m_valid_reg <= out_load;
            end
        end
    end

    always_ff @(posedge aclk) begin
        offset_reg    <= offset_next;
        last_byte_reg <= last_byte_next;
        if (out_free && out_load) begin
            m_data_reg  <= out_data;
            m_flags_reg <= out_flags;
            m_last_reg  <= out_last;
        end
    end

    lzsd_ram #(
        .DATA_W (8),
        .DEPTH  (WINDOW_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flags_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_copy_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (cnt_reg != 5'd0))
        else $error("copy state with zero remaining count");

    a_copy_below_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (bw_reg < out_len_reg))
        else $error("copy running past output length");

    a_done_sets_finished: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_free && out_load && (out_flags.done_ok || out_flags.bad_stream))
        |=> finished_reg)
        else $error("terminal result without finished state");

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_flags_reg.done_ok || m_flags_reg.bad_stream)) |-> m_last_reg)
        else $error("terminal result not marked last");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while a match or tail is pending");
`endif

endmodule
